// ===== design/multichannel_sensor_moving_average_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MULTICHANNEL_SENSOR_MOVING_AVERAGE_TOP_MACROS_SVH
`define MULTICHANNEL_SENSOR_MOVING_AVERAGE_TOP_MACROS_SVH

// Clocked on clk, muted while rst is high.
`define MSMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked on clk, checked during reset as well.
`define MSMA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/msma_pkg.sv =====
// ---------------------------------------------------------------------------
// msma_pkg
// Widths, register codes and shared types of the multichannel moving average.
// ---------------------------------------------------------------------------
`default_nettype none

package msma_pkg;

  localparam int CHANNELS  = 4;
  // Window length; a power of two, so the average is a plain shift.
  localparam int WINDOW    = 8;
  localparam int WIN_W     = $clog2(WINDOW);

  localparam int CH_W      = 2;
  localparam int RAW_P_W   = 24;
  localparam int RAW_T_W   = 16;
  localparam int P_W       = 24;
  localparam int T_W       = 20;
  localparam int P_GAIN_W  = 24;
  localparam int T_GAIN_W  = 16;
  localparam int P_SHIFT   = 23;
  localparam int T_SHIFT   = 12;
  localparam int P_PROD_W  = RAW_P_W + P_GAIN_W + 1;
  localparam int T_PROD_W  = RAW_T_W + T_GAIN_W;
  localparam int P_SUM_W   = P_W + WIN_W;
  localparam int T_SUM_W   = T_W + WIN_W;

  localparam int GAIN_REGS = 4;
  localparam int GR_W      = $clog2(GAIN_REGS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] PGAIN_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] TGAIN_BASE = CFG_IDX_W'(GAIN_REGS);

  localparam logic [P_GAIN_W-1:0] PGAIN_RESET = P_GAIN_W'(256);
  localparam logic [T_GAIN_W-1:0] TGAIN_RESET = T_GAIN_W'(4096);

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // One classified reading on its way from the front to the back.
  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            chan_ok;
    logic            neg;
    logic [P_W-1:0]  p_scaled;
    logic [T_W-1:0]  t_scaled;
  } msma_op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } msma_qstat_t;

endpackage

`default_nettype wire

// ===== design/msma_in_if.sv =====
// ---------------------------------------------------------------------------
// msma_in_if
// Input channel: one raw sensor reading per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface msma_in_if import msma_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      channel;
  logic [RAW_P_W-1:0]   raw_pressure;
  logic [RAW_T_W-1:0]   raw_temperature;

  modport source (output valid, channel, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, channel, raw_pressure, raw_temperature, output ready);
endinterface

`default_nettype wire

// ===== design/msma_out_if.sv =====
// ---------------------------------------------------------------------------
// msma_out_if
// Output channel: one pair of windowed averages per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface msma_out_if import msma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [P_W-1:0]   pressure_average;
  logic [T_W-1:0]   temperature_average;
  logic             rejected;

  modport source (output valid, out_channel, pressure_average, temperature_average,
                  rejected, input ready);
  modport sink   (input valid, out_channel, pressure_average, temperature_average,
                  rejected, output ready);
endinterface

`default_nettype wire

// ===== design/msma_front.sv =====
// ---------------------------------------------------------------------------
// msma_front
// Gain registers, input acceptance and scaling of pressure and temperature.
// ---------------------------------------------------------------------------
`default_nettype none

module msma_front import msma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msma_in_if.sink               sample_in,
  input  msma_qstat_t           qstat,
  output logic                  push,
  output msma_op_t              op
);

  logic [P_GAIN_W-1:0] pgain [GAIN_REGS];
  logic [T_GAIN_W-1:0] tgain [GAIN_REGS];

  logic [GR_W-1:0]          pidx;
  logic [GR_W-1:0]          tidx;
  logic [CFG_IDX_W-1:0]     toff;
  logic [P_GAIN_W-1:0]      cur_pgain;
  logic [T_GAIN_W-1:0]      cur_tgain;
  logic signed [P_PROD_W-1:0] p_prod;
  logic [T_PROD_W-1:0]      t_prod;

  assign toff = cfg_index - TGAIN_BASE;
  assign pidx = cfg_index[GR_W-1:0];
  assign tidx = toff[GR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GAIN_REGS; i++) begin
        pgain[i] <= PGAIN_RESET;
        tgain[i] <= TGAIN_RESET;
      end
    end else if (cfg_write) begin
      // Indexes below TGAIN_BASE hit the pressure gains, the rest the temperature gains.
      priority if (cfg_index < TGAIN_BASE) begin
        pgain[pidx] <= cfg_data[P_GAIN_W-1:0];
      end else begin
        tgain[tidx] <= cfg_data[T_GAIN_W-1:0];
      end
    end
  end

  assign sample_in.ready = !qstat.full;
  assign push            = sample_in.valid && !qstat.full;

  assign cur_pgain = pgain[sample_in.channel];
  assign cur_tgain = tgain[sample_in.channel];

  assign p_prod = $signed(sample_in.raw_pressure) * $signed({1'b0, cur_pgain});
  assign t_prod = T_PROD_W'(sample_in.raw_temperature) * T_PROD_W'(cur_tgain);

  always_comb begin
    op.channel  = sample_in.channel;
    op.chan_ok  = (32'(sample_in.channel) < CHANNELS);
    // Negative only when the raw value is negative and the gain is nonzero.
    op.neg      = sample_in.raw_pressure[RAW_P_W-1] && (cur_pgain != '0);
    op.p_scaled = p_prod[P_SHIFT+P_W-1:P_SHIFT];
    op.t_scaled = t_prod[T_SHIFT+T_W-1:T_SHIFT];
  end

endmodule

`default_nettype wire

// ===== design/msma_queue.sv =====
// ---------------------------------------------------------------------------
// msma_queue
// Short FIFO of scaled readings between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module msma_queue import msma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  msma_op_t    push_op,
  input  logic        pop,
  output msma_qstat_t qstat,
  output msma_op_t    head
);

  msma_op_t         slots [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QC_W'(1);
        2'b01:   count <= count - QC_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == QC_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== design/msma_back.sv =====
// ---------------------------------------------------------------------------
// msma_back
// Per-channel window rings, running sums, stored averages and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module msma_back import msma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  msma_qstat_t qstat,
  input  msma_op_t    head,
  output logic        pop,
  msma_out_if.source  average_out
);

  logic [P_W-1:0]     pwin [CHANNELS][WINDOW];
  logic [T_W-1:0]     twin [CHANNELS][WINDOW];
  logic [P_SUM_W-1:0] psum [CHANNELS];
  logic [T_SUM_W-1:0] tsum [CHANNELS];
  logic [P_W-1:0]     pavg [CHANNELS];
  logic [T_W-1:0]     tavg [CHANNELS];
  logic [WIN_W-1:0]   wptr [CHANNELS];

  logic               out_valid;
  logic               out_free;
  logic [WIN_W-1:0]   ptr;
  logic [P_W-1:0]     pval;
  logic [P_SUM_W-1:0] psum_next;
  logic [T_SUM_W-1:0] tsum_next;
  logic [P_W-1:0]     pavg_next;
  logic [T_W-1:0]     tavg_next;
  logic               update;

  assign out_free = !out_valid || average_out.ready;
  assign pop      = qstat.valid && out_free;
  assign update   = pop && head.chan_ok;

  always_comb begin
    ptr       = wptr[head.channel];
    // Replay the stored average into the ring when the pressure reading is negative.
    pval      = head.neg ? pavg[head.channel] : head.p_scaled;
    psum_next = psum[head.channel] - P_SUM_W'(pwin[head.channel][ptr])
                + P_SUM_W'(pval);
    tsum_next = tsum[head.channel] - T_SUM_W'(twin[head.channel][ptr])
                + T_SUM_W'(head.t_scaled);
    pavg_next = psum_next[P_SUM_W-1:WIN_W];
    tavg_next = tsum_next[T_SUM_W-1:WIN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < WINDOW; k++) begin
          pwin[c][k] <= '0;
          twin[c][k] <= '0;
        end
        psum[c] <= '0;
        tsum[c] <= '0;
        pavg[c] <= '0;
        tavg[c] <= '0;
        wptr[c] <= '0;
      end
    end else if (update) begin
      pwin[head.channel][ptr] <= pval;
      psum[head.channel]      <= psum_next;
      wptr[head.channel]      <= ptr + WIN_W'(1);
      if (!head.neg) begin
        twin[head.channel][ptr] <= head.t_scaled;
        tsum[head.channel]      <= tsum_next;
        pavg[head.channel]      <= pavg_next;
        tavg[head.channel]      <= tavg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (average_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      average_out.out_channel <= head.channel;
      priority if (!head.chan_ok) begin
        average_out.pressure_average    <= '0;
        average_out.temperature_average <= '0;
        average_out.rejected            <= 1'b1;
      end else if (head.neg) begin
        average_out.pressure_average    <= pavg[head.channel];
        average_out.temperature_average <= tavg[head.channel];
        average_out.rejected            <= 1'b1;
      end else begin
        average_out.pressure_average    <= pavg_next;
        average_out.temperature_average <= tavg_next;
        average_out.rejected            <= 1'b0;
      end
    end
  end

  assign average_out.valid = out_valid;

endmodule

`default_nettype wire

// ===== design/multichannel_sensor_moving_average_top.sv =====
// Multichannel sensor moving average.
// sample_in carries one reading per item: a channel number, a 24-bit two's-complement
// raw pressure and a 16-bit raw temperature. average_out returns exactly one item per
// reading, in order: the channel, the windowed pressure average (Q16.8), the
// windowed temperature average (Q12.8) and a rejected flag.
// Throughput is one item per cycle while average_out.ready is high. Scaling
// multipliers sit in the front; the back registers the ring and running-sum update
// of one channel as its reading is popped. A reading accepted from sample_in is
// written into the queue, popped by the back and registered onto average_out.
// A four-entry queue sits between front and back; when the receiver holds
// average_out.ready low, the queue fills and sample_in.ready drops once it is full.
// Reset (rst, synchronous) clears every window, sum, stored average and pointer,
// and sets pressure gains to 256 and temperature gains to 1.0 (4096). The user must
// write gains on cfg_write/cfg_index/cfg_data while the block is idle; not enforced.
// ---------------------------------------------------------------------------
// multichannel_sensor_moving_average_top
// Top level: gain port, front scaler, queue and window back end.
// ---------------------------------------------------------------------------
`default_nettype none

module multichannel_sensor_moving_average_top import msma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msma_in_if.sink               sample_in,
  msma_out_if.source            average_out
);

  msma_qstat_t qstat;
  msma_op_t    push_op;
  msma_op_t    head;
  logic        push;
  logic        pop;

  msma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (sample_in),
    .qstat     (qstat),
    .push      (push),
    .op        (push_op)
  );

  msma_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .qstat   (qstat),
    .head    (head)
  );

  msma_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head        (head),
    .pop         (pop),
    .average_out (average_out)
  );

endmodule

`default_nettype wire

// ===== design/msma_checker.sv =====
// ---------------------------------------------------------------------------
// msma_checker
// Port-level checks of the moving average block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multichannel_sensor_moving_average_top_macros.svh"

module msma_checker import msma_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_channel,
  input logic [P_W-1:0]  pressure_average,
  input logic [T_W-1:0]  temperature_average,
  input logic            rejected
);

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

  logic              in_acc;
  logic              out_acc;
  logic [PEND_W-1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(in_acc) - PEND_W'(out_acc);
    end
  end

  `MSMA_ASSERT(out_hold, out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(pressure_average) && $stable(temperature_average) && $stable(rejected), "result changed while stalled")
  `MSMA_ASSERT(no_invented, out_valid |-> pending != '0, "result without a pending item")
  `MSMA_ASSERT(capacity, pending <= PEND_W'(QUEUE_DEPTH + 1), "more items in flight than storage")
  `MSMA_ASSERT_RST(quiet_after_reset, $past(rst) && !rst |-> !out_valid, "result valid right after reset")

endmodule

bind multichannel_sensor_moving_average_top msma_checker u_msma_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (sample_in.valid),
  .in_ready            (sample_in.ready),
  .out_valid           (average_out.valid),
  .out_ready           (average_out.ready),
  .out_channel         (average_out.out_channel),
  .pressure_average    (average_out.pressure_average),
  .temperature_average (average_out.temperature_average),
  .rejected            (average_out.rejected)
);

`default_nettype wire
